// ===== rtl/fpas_pkg.sv =====
package fpas_pkg;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_INF   = 8'hFF;

    // Count of leading zeros of a 27-bit word (27 when zero).
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/fp32_add_sub_unit_core.sv =====
// Throughput: one transaction per cycle unless m_tready stalls the output.
// There are four register stages, the last being the output register.
// A stall on m_tready freezes the whole pipeline, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears every valid bit; payload registers are not reset.
module fp32_add_sub_unit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [1:0] cmd, [33:2] operand_a, [65:34] operand_b, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] result_bits
);

    // The pipeline advances whenever the output register is free or being drained.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- Stage 1: decode, specials, magnitude ordering ----------------
    logic [1:0]  cmd;
    logic [31:0] op_a, op_b, b_eff, big, lit;
    logic        nan_a, nan_b, inf_a, inf_b, swap;
    logic        spec_1;
    logic [31:0] spec_val_1;

    assign cmd  = s_tdata[1:0];
    assign op_a = s_tdata[33:2];
    assign op_b = s_tdata[65:34];
    assign b_eff = (cmd == fpas_pkg::CMD_SUB) ? {~op_b[31], op_b[30:0]} : op_b;
    assign nan_a = (op_a[30:23] == fpas_pkg::EXP_INF) && (op_a[22:0] != '0);
    assign nan_b = (op_b[30:23] == fpas_pkg::EXP_INF) && (op_b[22:0] != '0);
    assign inf_a = (op_a[30:23] == fpas_pkg::EXP_INF);
    assign inf_b = (op_b[30:23] == fpas_pkg::EXP_INF);
    assign swap  = b_eff[30:0] > op_a[30:0];
    assign big   = swap ? b_eff : op_a;
    assign lit   = swap ? op_a : b_eff;

    always_comb begin
        spec_1     = 1'b1;
        spec_val_1 = '0;
        if (cmd != fpas_pkg::CMD_ADD && cmd != fpas_pkg::CMD_SUB) begin
            spec_val_1 = '0;
        end else if (nan_a || nan_b) begin
            spec_val_1 = fpas_pkg::QNAN_BITS;
        end else if (inf_a && inf_b && (op_a[31] != b_eff[31])) begin
            spec_val_1 = fpas_pkg::QNAN_BITS;
        end else if (inf_a) begin
            spec_val_1 = op_a;
        end else if (inf_b) begin
            spec_val_1 = b_eff;
        end else begin
            spec_1 = 1'b0;
        end
    end

    logic        v1_reg;
    logic        spec1_reg;
    logic [31:0] spec_val1_reg, big1_reg, lit1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
        if (adv) begin
            spec1_reg     <= spec_1;
            spec_val1_reg <= spec_val_1;
            big1_reg      <= big;
            lit1_reg      <= lit;
        end
    end

    // ---------------- Stage 2: align the smaller operand, add or subtract ----------------
    logic [7:0]  ea, eb, d;
    logic [26:0] ma, mb, mb_sh;
    logic [27:0] sum_2;
    logic        sub_2, sticky;
    logic [26:0] mask;

    assign ea = (big1_reg[30:23] == '0) ? 8'd1 : big1_reg[30:23];
    assign eb = (lit1_reg[30:23] == '0) ? 8'd1 : lit1_reg[30:23];
    assign ma = {(big1_reg[30:23] != '0), big1_reg[22:0], 3'b000};
    assign mb = {(lit1_reg[30:23] != '0), lit1_reg[22:0], 3'b000};
    assign d  = ea - eb;
    assign sub_2 = big1_reg[31] != lit1_reg[31];

    always_comb begin
        mask   = '0;
        mb_sh  = '0;
        sticky = 1'b0;
        if (d > 8'd26) begin
            mb_sh = {26'd0, (mb != '0)};
        end else begin
            mask   = ~(27'h7FF_FFFF << d[4:0]);
            sticky = (mb & mask) != '0;
            mb_sh  = (mb >> d[4:0]) | {26'd0, sticky};
        end
        sum_2 = sub_2 ? ({1'b0, ma} - {1'b0, mb_sh}) : ({1'b0, ma} + {1'b0, mb_sh});
    end

    logic        v2_reg, spec2_reg, sub2_reg, sign2_reg;
    logic [31:0] spec_val2_reg;
    logic [27:0] sum2_reg;
    logic [7:0]  e2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            spec2_reg     <= spec1_reg;
            spec_val2_reg <= spec_val1_reg;
            sub2_reg      <= sub_2;
            sign2_reg     <= big1_reg[31];
            sum2_reg      <= sum_2;
            e2_reg        <= ea;
        end
    end

    // ---------------- Stage 3: normalize ----------------
    logic [4:0]  lz;
    logic [7:0]  sh;
    logic [26:0] norm_3;
    logic [8:0]  e_3;
    logic        zero_3;

    assign lz = fpas_pkg::lzc27(sum2_reg[26:0]);

    always_comb begin
        zero_3 = 1'b0;
        sh     = '0;
        norm_3 = sum2_reg[26:0];
        e_3    = {1'b0, e2_reg};
        if (!sub2_reg) begin
            if (sum2_reg[27]) begin
                norm_3 = sum2_reg[27:1] | {26'd0, sum2_reg[0]};
                e_3    = {1'b0, e2_reg} + 9'd1;
            end
        end else if (sum2_reg == '0) begin
            zero_3 = 1'b1;
        end else begin
            // Shift left until normalized, but never below exponent one.
            sh     = ({3'd0, lz} < (e2_reg - 8'd1)) ? {3'd0, lz} : (e2_reg - 8'd1);
            norm_3 = sum2_reg[26:0] << sh[4:0];
            e_3    = {1'b0, e2_reg - sh};
        end
    end

    logic        v3_reg, spec3_reg, sign3_reg;
    logic [31:0] spec_val3_reg;
    logic [26:0] norm3_reg;
    logic [8:0]  e3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            spec3_reg     <= spec2_reg || zero_3;
            spec_val3_reg <= spec2_reg ? spec_val2_reg : '0;
            sign3_reg     <= sign2_reg;
            norm3_reg     <= norm_3;
            e3_reg        <= e_3;
        end
    end

    // ---------------- Stage 4: round to nearest even, pack ----------------
    logic [2:0]  grs;
    logic [24:0] mant;
    logic [8:0]  e_4;
    logic [31:0] res_4;

    assign grs = norm3_reg[2:0];

    always_comb begin
        mant = {1'b0, norm3_reg[26:3]};
        if (grs > 3'd4 || (grs == 3'd4 && norm3_reg[3])) begin
            mant = mant + 25'd1;
        end
        e_4 = e3_reg;
        if (mant[24]) begin
            mant = mant >> 1;
            e_4  = e3_reg + 9'd1;
        end
        if (spec3_reg) begin
            res_4 = spec_val3_reg;
        end else if (e_4 >= {1'b0, fpas_pkg::EXP_INF}) begin
            res_4 = {sign3_reg, fpas_pkg::EXP_INF, 23'd0};
        end else if (!mant[23]) begin
            res_4 = {sign3_reg, 8'd0, mant[22:0]};
        end else begin
            res_4 = {sign3_reg, e_4[7:0], mant[22:0]};
        end
    end

    logic        m_valid_reg;
    logic [31:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v3_reg;
        end
        if (adv) begin
            m_data_reg <= res_4;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // A stalled result must hold its data until the transaction completes.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // An accepted input reaches the output through v1_reg, v2_reg, v3_reg and the output register when never stalled.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 s_tready ##1 s_tready ##1 s_tready |=> m_tvalid)
        else $error("transaction lost in pipeline");
    // Results never carry a NaN pattern other than the canonical one.
    a_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30:23] == 8'hFF && m_tdata[22:0] != 23'd0
        |-> m_tdata == fpas_pkg::QNAN_BITS)
        else $error("non-canonical NaN");
`endif

endmodule
